>>> src/wwa_pkg.sv
// Package for the weighted window average core.
// Holds the sizes, the controller state type and the command and status structs.
// Uses nothing else; every other file imports it.
package wwa_pkg;

   localparam int MAX_WINDOW   = 64;
   localparam int WINDOW_RESET = 10;
   localparam int SAMPLE_W     = 16;
   localparam int AVG_W        = 16;
   localparam int WL_W         = 7;
   localparam int IDX_W        = $clog2(MAX_WINDOW);
   localparam int FILL_W       = $clog2(MAX_WINDOW + 1);
   localparam int PROD_W       = 32;
   localparam int SUM_W        = 39;
   localparam int WT_W         = 23;
   localparam int CNT_W        = $clog2(SUM_W + 1);
   localparam int ENTRY_W      = 3 * SAMPLE_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL_OH,
      ST_MUL_OP,
      ST_MUL_NH,
      ST_MUL_NP,
      ST_ACC_NP,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      MUL_OLD_H,
      MUL_OLD_P,
      MUL_NEW_H,
      MUL_NEW_P
   } mul_sel_type;

   typedef struct packed {
      logic             clear;
      logic             capture;
      logic             mem_we;
      mul_sel_type      mul_sel;
      logic             acc_en;
      logic             acc_pitch;
      logic             acc_sub;
      logic             wt_update;
      logic             full;
      logic             div_start;
      logic             load_out;
      logic [IDX_W-1:0] slot;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
   } dp_status_type;

endpackage

>>> src/wwa_req_if.sv
// Input channel of the weighted window average core: one estimate per beat.
// Depends on wwa_pkg for the sample width.
interface wwa_req_if import wwa_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] height_in;
   logic signed [SAMPLE_W-1:0] pitch_in;
   logic        [SAMPLE_W-1:0] weight_in;

   modport source (output valid, output height_in, output pitch_in, output weight_in,
                   input ready);
   modport sink   (input valid, input height_in, input pitch_in, input weight_in,
                   output ready);
endinterface

>>> src/wwa_rsp_if.sv
// Result channel of the weighted window average core: one average pair per beat.
// Depends on wwa_pkg for the average width.
interface wwa_rsp_if import wwa_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [AVG_W-1:0] height_avg;
   logic signed [AVG_W-1:0] pitch_avg;
   logic                    zero_weight;

   modport source (output valid, output height_avg, output pitch_avg, output zero_weight,
                   input ready);
   modport sink   (input valid, input height_avg, input pitch_avg, input zero_weight,
                   output ready);
endinterface

>>> src/wwa_div.sv
// Bit-serial signed divider: one quotient bit per cycle, truncates toward zero.
// Depends on wwa_pkg; instantiated twice by wwa_dp.
module wwa_div import wwa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [SUM_W-1:0] dividend,
   input  logic        [WT_W-1:0]  divisor,
   output logic                    done,
   output logic signed [AVG_W-1:0] quotient
);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             neg_ff;
   logic [SUM_W-1:0] quo_ff;
   logic [WT_W-1:0]  rem_ff;
   logic [WT_W-1:0]  dsr_ff;

   logic [WT_W:0]    rem_shift;
   logic [WT_W:0]    diff;
   logic             ge;
   logic [SUM_W-1:0] mag;
   logic [AVG_W-1:0] q_lo;

   assign rem_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign diff      = rem_shift - {1'b0, dsr_ff};
   assign ge        = (rem_shift >= {1'b0, dsr_ff});
   assign mag       = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
   assign q_lo      = quo_ff[AVG_W-1:0];
   assign quotient  = neg_ff ? (~q_lo + 1'b1) : q_lo;
   assign done      = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(SUM_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[SUM_W-1];
         quo_ff <= mag;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[WT_W-1:0] : rem_shift[WT_W-1:0];
         quo_ff <= {quo_ff[SUM_W-2:0], ge};
      end
   end

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && !done_ff)
      else $error("divider did not start");
   a_busy_done_excl: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("divider busy and done together");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> int'(cnt_ff) < SUM_W)
      else $error("divider step count beyond dividend width");

endmodule

>>> src/wwa_dp.sv
// Datapath: ring store, shared multiplier, running sums and the two dividers.
// Depends on wwa_pkg and wwa_div; driven by wwa_ctrl through dp_cmd_type.
module wwa_dp import wwa_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 cmd,
   output dp_status_type              status,
   input  logic signed [SAMPLE_W-1:0] height_in,
   input  logic signed [SAMPLE_W-1:0] pitch_in,
   input  logic        [SAMPLE_W-1:0] weight_in,
   output logic signed [AVG_W-1:0]    height_avg,
   output logic signed [AVG_W-1:0]    pitch_avg,
   output logic                       zero_weight
);

   logic [ENTRY_W-1:0] entry_mem [MAX_WINDOW];
   logic [ENTRY_W-1:0] rd_ff;

   logic signed [SAMPLE_W-1:0] h_ff;
   logic signed [SAMPLE_W-1:0] p_ff;
   logic        [SAMPLE_W-1:0] w_ff;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0]  hsum_ff;
   logic signed [SUM_W-1:0]  psum_ff;
   logic        [WT_W-1:0]   wt_ff;

   logic signed [AVG_W-1:0] havg_ff;
   logic signed [AVG_W-1:0] pavg_ff;
   logic                    zero_ff;

   logic        [SAMPLE_W-1:0] old_w;
   logic signed [SAMPLE_W-1:0] old_h;
   logic signed [SAMPLE_W-1:0] old_p;
   logic        [SAMPLE_W-1:0] mul_a;
   logic signed [SAMPLE_W-1:0] mul_b;
   logic signed [SAMPLE_W:0]   mul_a_s;
   logic signed [2*SAMPLE_W:0] mul_full;
   logic signed [SUM_W-1:0]    prod_ext;
   logic        [WT_W-1:0]     old_w_ext;

   logic                    hdone;
   logic                    pdone;
   logic signed [AVG_W-1:0] hq;
   logic signed [AVG_W-1:0] pq;

   assign old_h = rd_ff[SAMPLE_W-1:0];
   assign old_p = rd_ff[2*SAMPLE_W-1:SAMPLE_W];
   assign old_w = rd_ff[3*SAMPLE_W-1:2*SAMPLE_W];

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         entry_mem[cmd.slot] <= {w_ff, p_ff, h_ff};
         rd_ff               <= entry_mem[cmd.slot];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         h_ff <= height_in;
         p_ff <= pitch_in;
         w_ff <= weight_in;
      end
   end

   always_comb begin
      case (cmd.mul_sel)
         MUL_OLD_H: begin mul_a = old_w; mul_b = old_h; end
         MUL_OLD_P: begin mul_a = old_w; mul_b = old_p; end
         MUL_NEW_H: begin mul_a = w_ff;  mul_b = h_ff;  end
         default:   begin mul_a = w_ff;  mul_b = p_ff;  end
      endcase
   end

   assign mul_a_s   = $signed({1'b0, mul_a});
   assign mul_full  = mul_a_s * mul_b;
   assign prod_ext  = {{(SUM_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign old_w_ext = cmd.full ? {{(WT_W-SAMPLE_W){1'b0}}, old_w} : '0;

   always_ff @(posedge clock) begin
      prod_ff <= mul_full[PROD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         hsum_ff <= '0;
         psum_ff <= '0;
         wt_ff   <= '0;
      end else begin
         if (cmd.acc_en && !cmd.acc_pitch) begin
            hsum_ff <= cmd.acc_sub ? hsum_ff - prod_ext : hsum_ff + prod_ext;
         end
         if (cmd.acc_en && cmd.acc_pitch) begin
            psum_ff <= cmd.acc_sub ? psum_ff - prod_ext : psum_ff + prod_ext;
         end
         if (cmd.wt_update) begin
            wt_ff <= wt_ff - old_w_ext + {{(WT_W-SAMPLE_W){1'b0}}, w_ff};
         end
      end
   end

   wwa_div u_hdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (hsum_ff),
      .divisor  (wt_ff),
      .done     (hdone),
      .quotient (hq)
   );

   wwa_div u_pdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (psum_ff),
      .divisor  (wt_ff),
      .done     (pdone),
      .quotient (pq)
   );

   assign status.div_done = hdone && pdone;

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         zero_ff <= (wt_ff == '0);
         havg_ff <= (wt_ff == '0) ? '0 : hq;
         pavg_ff <= (wt_ff == '0) ? '0 : pq;
      end
   end

   assign height_avg  = havg_ff;
   assign pitch_avg   = pavg_ff;
   assign zero_weight = zero_ff;

endmodule

>>> src/wwa_ctrl.sv
// Controller: window length register, ring pointer, fill count and the step sequencer.
// Depends on wwa_pkg; commands wwa_dp through dp_cmd_type.
module wwa_ctrl import wwa_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  logic            csr_we,
   input  logic [WL_W-1:0] csr_wdata,
   output dp_cmd_type      cmd,
   input  dp_status_type   status
);

   state_type         state_ff;
   state_type         state_in;
   logic [WL_W-1:0]   wl_ff;
   logic [IDX_W-1:0]  wslot_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [IDX_W-1:0]  slot_ff;
   logic              full_ff;
   logic              rsp_valid_ff;

   logic [FILL_W-1:0] len;
   logic [FILL_W-1:0] slot_sel;
   logic [FILL_W-1:0] slot_inc;
   logic [IDX_W-1:0]  slot_next;
   logic              full;
   logic              accept;

   always_comb begin
      if (wl_ff == '0) begin
         len = FILL_W'(1);
      end else if (int'(wl_ff) > MAX_WINDOW) begin
         len = FILL_W'(MAX_WINDOW);
      end else begin
         len = FILL_W'(wl_ff);
      end
   end

   assign slot_sel  = (FILL_W'(wslot_ff) >= len) ? '0 : FILL_W'(wslot_ff);
   assign slot_inc  = slot_sel + 1'b1;
   assign slot_next = (slot_inc >= len) ? '0 : slot_inc[IDX_W-1:0];
   assign full      = (fill_ff >= len);
   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wl_ff        <= WL_W'(WINDOW_RESET);
         wslot_ff     <= '0;
         fill_ff      <= '0;
         slot_ff      <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            wl_ff    <= csr_wdata;
            wslot_ff <= '0;
            fill_ff  <= '0;
         end else if (accept) begin
            wslot_ff <= slot_next;
            fill_ff  <= full ? fill_ff : fill_ff + 1'b1;
            slot_ff  <= slot_sel[IDX_W-1:0];
            full_ff  <= full;
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.mul_sel   = MUL_OLD_H;
      cmd.slot      = slot_ff;
      cmd.full      = full_ff;
      cmd.clear     = csr_we;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.mem_we = 1'b1;
            state_in   = ST_MUL_OH;
         end
         ST_MUL_OH: begin
            cmd.mul_sel   = MUL_OLD_H;
            cmd.wt_update = 1'b1;
            state_in      = ST_MUL_OP;
         end
         ST_MUL_OP: begin
            cmd.mul_sel = MUL_OLD_P;
            cmd.acc_en  = full_ff;
            cmd.acc_sub = 1'b1;
            state_in    = ST_MUL_NH;
         end
         ST_MUL_NH: begin
            cmd.mul_sel   = MUL_NEW_H;
            cmd.acc_en    = full_ff;
            cmd.acc_pitch = 1'b1;
            cmd.acc_sub   = 1'b1;
            state_in      = ST_MUL_NP;
         end
         ST_MUL_NP: begin
            cmd.mul_sel = MUL_NEW_P;
            cmd.acc_en  = 1'b1;
            state_in    = ST_ACC_NP;
         end
         ST_ACC_NP: begin
            cmd.acc_en    = 1'b1;
            cmd.acc_pitch = 1'b1;
            state_in      = ST_DIV_START;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      int'(fill_ff) <= MAX_WINDOW)
      else $error("fill count beyond window");
   a_accept_read: assert property (@(posedge clock) disable iff (reset)
      accept && !csr_we |=> state_ff == ST_READ)
      else $error("accepted beat not sequenced");
   a_out_done: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_OUT) |-> $past(status.div_done))
      else $error("result loaded before division finished");

endmodule

>>> src/weighted_window_average_two_channel_core.sv
// Top level of the two-channel weighted window average core.
// Depends on wwa_pkg, wwa_req_if, wwa_rsp_if, wwa_ctrl and wwa_dp.
//
//   channel   direction  beat contents
//   req_ch    in         height_in, pitch_in (signed), weight_in (unsigned)
//   rsp_ch    out        height_avg, pitch_avg (signed), zero_weight
//   csr_*     in         window_length write, clears the window
//
// A new item is accepted only after the previous one has been handed to the output
// register; its quotient is found by the bit-serial steps of the two dividers,
// which run side by side.
// Reset is synchronous, active high; window length returns to 10, window empty.
// A waiting result is held in the output register; a stalled result delays
// only the hand-off of the next one, not its acceptance.
module weighted_window_average_two_channel_core import wwa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   wwa_req_if.sink          req_ch,
   wwa_rsp_if.source        rsp_ch,
   input  logic             csr_we,
   input  logic [WL_W-1:0]  csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   wwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

   wwa_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .height_in   (req_ch.height_in),
      .pitch_in    (req_ch.pitch_in),
      .weight_in   (req_ch.weight_in),
      .height_avg  (rsp_ch.height_avg),
      .pitch_avg   (rsp_ch.pitch_avg),
      .zero_weight (rsp_ch.zero_weight)
   );

endmodule
